// ----- rtl/ep2cal_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ep2cal_pkg
// Constants for the epoch-seconds to calendar pipeline: reciprocal
// multipliers for the constant divides and the day tables.
// ----------------------------------------------------------------------------
package ep2cal_pkg;

  localparam int unsigned SecsPerMin   = 60;
  localparam int unsigned MinsPerHour  = 60;
  localparam int unsigned HoursPerDay  = 24;
  localparam int unsigned DaysPerCycle = 365 * 4 + 1;

  localparam int unsigned PipeDepth = 6;

  // floor(x / d) == (x * RECIP) >> SHIFT, exact over each operand range
  // x / 60 on 32 bits: (x >> 2) / 15
  localparam logic [31:0] RECIP_DIV15_A = 32'd2290649225;
  localparam int unsigned SHIFT_DIV15_A = 35;
  // x / 60 on 27 bits: (x >> 2) / 15
  localparam logic [27:0] RECIP_DIV15_B = 28'd143165577;
  localparam int unsigned SHIFT_DIV15_B = 31;
  // x / 24 on 21 bits: (x >> 3) / 3
  localparam logic [18:0] RECIP_DIV3    = 19'd349526;
  localparam int unsigned SHIFT_DIV3    = 20;
  // x / 1461 on 16 bits
  localparam logic [16:0] RECIP_DIV1461 = 17'd91868;
  localparam int unsigned SHIFT_DIV1461 = 27;

  typedef logic [10:0] cycle_day_t;
  typedef logic [8:0]  year_day_t;

  // cycle runs common, common, leap, common
  localparam cycle_day_t YEAR_START [0:3] = '{11'd0, 11'd365, 11'd730, 11'd1096};
  localparam logic [1:0] LEAP_YEAR_IDX = 2'd2;

  // days before each month, common row then leap row
  localparam year_day_t MONTH_START [0:1][0:11] = '{
    '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334},
    '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335}
  };

endpackage
`default_nettype wire

// ----- rtl/epoch_seconds_to_calendar_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core
// Converts a 32-bit seconds-since-1970 count into time of day and date.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: present in_epoch_seconds with in_valid; the item is
//   taken on a clock edge with in_valid high and in_stall low.
//   Output channel out_*: one result item per input item, in order, held
//   with out_valid until an edge with out_stall low.
//   Six register stages, the first loaded at the accepting edge. One item per
//   cycle is sustained while no valid result is stalled at the output. The
//   six stages are the chain of constant divides (by 60, 60, 24 and 1461,
//   each a reciprocal multiply), the cycle-year split and the month lookup.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall rises in the same cycle; bubbles never block the pipe.
//   Synchronous reset (rst_n low) clears all valid bits; no item is in
//   flight afterwards.
//   Every fourth year counts as leap, 2100 included.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_epoch_seconds,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_second_of_minute,
  output logic [5:0]       out_minute_of_hour,
  output logic [4:0]       out_hour_of_day,
  output logic [4:0]       out_day_of_month,
  output logic [3:0]       out_month_number,
  output logic [7:0]       out_year_offset
);

  localparam int unsigned Depth = ep2cal_pkg::PipeDepth;

  logic             advance;
  logic [Depth-1:0] vld_r, vld_nxt;

  // stage 1: minutes total
  logic [61:0] s1_prod;
  logic [31:0] s1_t_r;
  logic [26:0] s1_q_r;
  // stage 2: seconds, hours total
  logic [52:0] s2_prod;
  logic [5:0]  s2_sec_r;
  logic [26:0] s2_min_tot_r;
  logic [20:0] s2_q_r;
  // stage 3: minutes, days total
  logic [36:0] s3_prod;
  logic [5:0]  s3_sec_r, s3_min_r;
  logic [20:0] s3_hr_tot_r;
  logic [15:0] s3_q_r;
  // stage 4: hours, four-year cycles
  logic [33:0] s4_prod;
  logic [5:0]  s4_sec_r, s4_min_r;
  logic [4:0]  s4_hr_r;
  logic [15:0] s4_days_r;
  logic [5:0]  s4_cyc_r;
  // stage 5: cycle year and day of year
  ep2cal_pkg::cycle_day_t s5_rem;
  logic [1:0]             s5_yr;
  ep2cal_pkg::year_day_t  s5_doy;
  logic [5:0]             s5_sec_r, s5_min_r, s5_cyc_r;
  logic [4:0]             s5_hr_r;
  logic [1:0]             s5_yr_r;
  ep2cal_pkg::year_day_t  s5_doy_r;
  // stage 6: month lookup
  logic                   s6_leap;
  logic [3:0]             s6_mon;
  ep2cal_pkg::year_day_t  s6_mday;

  assign out_valid = vld_r[Depth-1];
  assign advance   = !(vld_r[Depth-1] && out_stall);
  assign in_stall  = !advance;

  assign vld_nxt = {vld_r[Depth-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= vld_nxt;
    end
  end

  // arithmetic per stage
  assign s1_prod = 62'(in_epoch_seconds[31:2]) * 62'(ep2cal_pkg::RECIP_DIV15_A);
  assign s2_prod = 53'(s1_q_r[26:2]) * 53'(ep2cal_pkg::RECIP_DIV15_B);
  assign s3_prod = 37'(s2_q_r[20:3]) * 37'(ep2cal_pkg::RECIP_DIV3);
  assign s4_prod = 34'(s3_q_r) * 34'(ep2cal_pkg::RECIP_DIV1461);

  // cycle days below 1461 fit 11 bits, so the low bits of the product suffice
  assign s5_rem = 11'(s4_days_r[10:0] - 11'(11'(s4_cyc_r) * 11'(ep2cal_pkg::DaysPerCycle)));

  always_comb begin
    s5_yr = 2'd0;
    for (int i = 1; i < 4; i++) begin
      if (s5_rem >= ep2cal_pkg::YEAR_START[i]) begin
        s5_yr = 2'(i);
      end
    end
    s5_doy = 9'(s5_rem - ep2cal_pkg::YEAR_START[s5_yr]);
  end

  assign s6_leap = (s5_yr_r == ep2cal_pkg::LEAP_YEAR_IDX);

  always_comb begin
    s6_mon = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (s5_doy_r >= ep2cal_pkg::MONTH_START[s6_leap][i]) begin
        s6_mon = 4'(i);
      end
    end
    s6_mday = 9'(s5_doy_r - ep2cal_pkg::MONTH_START[s6_leap][s6_mon]);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_t_r <= in_epoch_seconds;
      s1_q_r <= s1_prod[ep2cal_pkg::SHIFT_DIV15_A +: 27];

      s2_sec_r     <= 6'(s1_t_r[5:0] - 6'(s1_q_r[5:0] * 6'(ep2cal_pkg::SecsPerMin)));
      s2_min_tot_r <= s1_q_r;
      s2_q_r       <= s2_prod[ep2cal_pkg::SHIFT_DIV15_B +: 21];

      s3_sec_r    <= s2_sec_r;
      s3_min_r    <= 6'(s2_min_tot_r[5:0] - 6'(s2_q_r[5:0] * 6'(ep2cal_pkg::MinsPerHour)));
      s3_hr_tot_r <= s2_q_r;
      s3_q_r      <= s3_prod[ep2cal_pkg::SHIFT_DIV3 +: 16];

      s4_sec_r  <= s3_sec_r;
      s4_min_r  <= s3_min_r;
      s4_hr_r   <= 5'(s3_hr_tot_r[4:0] - 5'(s3_q_r[4:0] * 5'(ep2cal_pkg::HoursPerDay)));
      s4_days_r <= s3_q_r;
      s4_cyc_r  <= s4_prod[ep2cal_pkg::SHIFT_DIV1461 +: 6];

      s5_sec_r <= s4_sec_r;
      s5_min_r <= s4_min_r;
      s5_hr_r  <= s4_hr_r;
      s5_cyc_r <= s4_cyc_r;
      s5_yr_r  <= s5_yr;
      s5_doy_r <= s5_doy;

      out_second_of_minute <= s5_sec_r;
      out_minute_of_hour   <= s5_min_r;
      out_hour_of_day      <= s5_hr_r;
      out_day_of_month     <= 5'(s6_mday + 9'd1);
      out_month_number     <= s6_mon + 4'd1;
      out_year_offset      <= {s5_cyc_r, 2'b00} + 8'(s5_yr_r);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ep2cal_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ep2cal_checker
// Port-level checks for epoch_seconds_to_calendar_core, bound to the core.
// ----------------------------------------------------------------------------
module ep2cal_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [5:0] out_second_of_minute,
  input wire logic [5:0] out_minute_of_hour,
  input wire logic [4:0] out_hour_of_day,
  input wire logic [4:0] out_day_of_month,
  input wire logic [3:0] out_month_number,
  input wire logic [7:0] out_year_offset
);

  // pipeline freezes as a whole behind a stalled result
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_year_offset)
      && $stable(out_day_of_month) && $stable(out_second_of_minute))
    else $error("stalled result changed");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_second_of_minute < 6'd60 && out_minute_of_hour < 6'd60
      && out_hour_of_day < 5'd24 && out_day_of_month != 5'd0
      && out_month_number != 4'd0 && out_month_number < 4'd13
      && out_year_offset < 8'd137)
    else $error("result field out of range");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind epoch_seconds_to_calendar_core ep2cal_checker u_ep2cal_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_second_of_minute (out_second_of_minute),
  .out_minute_of_hour   (out_minute_of_hour),
  .out_hour_of_day      (out_hour_of_day),
  .out_day_of_month     (out_day_of_month),
  .out_month_number     (out_month_number),
  .out_year_offset      (out_year_offset)
);
`default_nettype wire
